FILE: hw/rtl/button_gesture_recognizer_top_macros.svh
`ifndef BUTTON_GESTURE_RECOGNIZER_TOP_MACROS_SVH
`define BUTTON_GESTURE_RECOGNIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define BGR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button gesture check failed");

// Next-cycle implication, sampled on clk, off during reset
`define BGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button gesture check failed");

`endif

FILE: hw/rtl/bgr_pkg.sv
`default_nettype none

package bgr_pkg;

  localparam int TimeW = 48;
  localparam int GenW  = 32;
  localparam int CfgW  = 16;

  localparam logic [CfgW-1:0] LongPressReset = 16'd800;
  localparam logic [CfgW-1:0] ClickGapReset  = 16'd300;

  localparam logic [1:0] TripleKey   = 2'd2;
  localparam logic [1:0] InvalidKey  = 2'd3;
  localparam logic [1:0] TripleCount = 2'd3;
  localparam logic signed [2:0] NoKey = -3'sd1;

  // Configuration register indexes
  localparam logic CfgLongPress = 1'b0;
  localparam logic CfgClickGap  = 1'b1;

  typedef enum logic [1:0] {
    MODE_RAW    = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_SCREEN = 2'd2,
    MODE_CANCEL = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_CLICK  = 3'd1,
    ACT_DOUBLE = 3'd2,
    ACT_LONG   = 3'd3,
    ACT_OFF    = 3'd4,
    ACT_WAKE   = 3'd5
  } action_t;

  typedef struct packed {
    mode_t            mode;
    logic [1:0]       key;
    logic             pressed;
    logic             screen_request;
    logic [GenW-1:0]  generation;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    action_t            action;
    logic signed [2:0]  action_key;
    logic [GenW-1:0]    action_generation;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bgr_elapsed.sv
`default_nettype none

// Checks that at least limit ms have passed from since_ms to now_ms
module bgr_elapsed
  import bgr_pkg::*;
(
  input  wire logic [TimeW-1:0] now_ms,
  input  wire logic [TimeW-1:0] since_ms,
  input  wire logic [CfgW-1:0]  limit,
  output logic                  met
);

  logic [TimeW:0] diff;

  // borrow out of the subtract flags time running backwards
  assign diff   = {1'b0, now_ms} - {1'b0, since_ms};
  assign met    = !diff[TimeW] && (diff[TimeW-1:0] >= {{(TimeW-CfgW){1'b0}}, limit});

endmodule

`default_nettype wire

FILE: hw/rtl/bgr_core.sv
`default_nettype none

// Gesture state and its one-pass update for one item
module bgr_core
  import bgr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire item_t           item,
  input  wire logic [CfgW-1:0] long_press_ms,
  input  wire logic [CfgW-1:0] click_gap_ms,
  output result_t              res
);

  typedef struct packed {
    logic             screen_is_on;
    logic             barrier_active;
    logic             barrier_wants_release;
    logic [2:0]       held_keys;
    logic             seq_valid;
    logic [1:0]       seq_key;
    logic             seq_held;
    logic             long_reported;
    logic [1:0]       click_count;
    logic [GenW-1:0]  seq_generation;
    logic [TimeW-1:0] press_time;
    logic [TimeW-1:0] release_time;
    logic [TimeW-1:0] last_event_time;
  } st_t;

  st_t st;
  st_t st_next;

  logic el_last_behind, el_last;
  logic el_press;
  logic el_rel;
  logic lift;
  logic [2:0] kbit;
  logic goes_on;
  logic [1:0] cnt;

  function automatic st_t clear_seq(st_t s);
    st_t t;
    t = s;
    t.seq_valid     = 1'b0;
    t.seq_key       = 2'd0;
    t.seq_held      = 1'b0;
    t.long_reported = 1'b0;
    t.click_count   = 2'd0;
    return t;
  endfunction

  function automatic st_t screen_set(st_t s, logic on, logic [TimeW-1:0] now);
    st_t t;
    t = clear_seq(s);
    t.screen_is_on          = on;
    t.barrier_active        = 1'b1;
    t.barrier_wants_release = (s.held_keys != 3'd0);
    t.last_event_time       = now;
    return t;
  endfunction

  // three time comparators, all against the stored stamps
  bgr_elapsed u_el_last (
    .now_ms  (item.now_ms),
    .since_ms(st.last_event_time),
    .limit   (click_gap_ms),
    .met     (el_last)
  );

  bgr_elapsed u_el_press (
    .now_ms  (item.now_ms),
    .since_ms(st.press_time),
    .limit   (long_press_ms),
    .met     (el_press)
  );

  bgr_elapsed u_el_rel (
    .now_ms  (item.now_ms),
    .since_ms(st.release_time),
    .limit   (click_gap_ms),
    .met     (el_rel)
  );

  // raw events older than the last one are dropped
  assign el_last_behind = (item.now_ms < st.last_event_time);

  assign lift = st.barrier_active && (st.held_keys == 3'd0) &&
                !st.barrier_wants_release && el_last;
  assign kbit = 3'b001 << item.key;

  // next state and result
  always_comb begin
    st_next = st;
    res.action            = ACT_NONE;
    res.action_key        = NoKey;
    res.action_generation = '0;
    goes_on = 1'b0;
    cnt = st.click_count;
    case (item.mode)
      MODE_TICK: begin
        if (lift) st_next.barrier_active = 1'b0;
        if (st_next.barrier_active || !st.screen_is_on || !st.seq_valid) begin
          // nothing to report
        end else if (st.seq_generation != item.generation) begin
          st_next = clear_seq(st_next);
        end else if (st.seq_held && !st.long_reported && el_press) begin
          st_next.long_reported = 1'b1;
          st_next.click_count   = 2'd0;
          res.action            = ACT_LONG;
          res.action_key        = {1'b0, st.seq_key};
          res.action_generation = st.seq_generation;
        end else if (!st.seq_held && el_rel) begin
          // sequence over: report clicks, or none with the sequence tag
          st_next = clear_seq(st_next);
          case (st.click_count)
            2'd1:    res.action = ACT_CLICK;
            2'd2:    res.action = ACT_DOUBLE;
            default: res.action = ACT_NONE;
          endcase
          res.action_key        = {1'b0, st.seq_key};
          res.action_generation = st.seq_generation;
        end
      end
      MODE_RAW: begin
        if (item.key != InvalidKey && !el_last_behind) begin
          if (lift) st_next.barrier_active = 1'b0;
          st_next.last_event_time = item.now_ms;
          if (item.pressed && (st.held_keys & kbit) != 3'd0) begin
            // repeated press of a held key
          end else begin
            if (item.pressed) begin
              st_next.held_keys = st.held_keys | kbit;
            end else begin
              st_next.held_keys = st.held_keys & ~kbit;
              if (st_next.held_keys == 3'd0) st_next.barrier_wants_release = 1'b0;
            end
            if (st_next.barrier_active) begin
              // blocked
            end else if (!st.screen_is_on) begin
              if (item.pressed) begin
                st_next = screen_set(st_next, 1'b1, item.now_ms);
                res.action            = ACT_WAKE;
                res.action_key        = {1'b0, item.key};
                res.action_generation = item.generation;
              end
            end else if (item.pressed) begin
              goes_on = st.seq_valid && st.seq_key == item.key && !st.seq_held &&
                        !st.long_reported && st.seq_generation == item.generation &&
                        !el_rel;
              if (!goes_on) st_next = clear_seq(st_next);
              st_next.seq_valid      = 1'b1;
              st_next.seq_key        = item.key;
              st_next.seq_generation = item.generation;
              st_next.seq_held       = 1'b1;
              st_next.press_time     = item.now_ms;
            end else if (st.seq_valid && st.seq_key == item.key && st.seq_held &&
                         st.seq_generation == item.generation) begin
              st_next.seq_held     = 1'b0;
              st_next.release_time = item.now_ms;
              if (st.long_reported) begin
                st_next = clear_seq(st_next);
              end else if (el_press) begin
                st_next = clear_seq(st_next);
                res.action            = ACT_LONG;
                res.action_key        = {1'b0, item.key};
                res.action_generation = st.seq_generation;
              end else begin
                if (st.click_count != TripleCount) cnt = st.click_count + 2'd1;
                st_next.click_count = cnt;
                if (item.key == TripleKey && cnt == TripleCount) begin
                  st_next = screen_set(st_next, 1'b0, item.now_ms);
                  res.action            = ACT_OFF;
                  res.action_key        = {1'b0, item.key};
                  res.action_generation = st.seq_generation;
                end
              end
            end
          end
        end
      end
      MODE_SCREEN: begin
        st_next = screen_set(st, item.screen_request, item.now_ms);
      end
      MODE_CANCEL: begin
        st_next = clear_seq(st);
        st_next.barrier_active        = 1'b1;
        st_next.barrier_wants_release = 1'b1;
        st_next.last_event_time       = item.now_ms;
        st_next.held_keys             = 3'd0;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  // state register, updated once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      // screen on (top field), everything else clear
      st <= st_t'({1'b1, {($bits(st_t)-1){1'b0}}});
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/button_gesture_recognizer_top.sv
// Path: an accepted item is loaded into the input register, and its result is
// loaded into the result register when the item advances out of the input one.
// Throughput: one item per cycle; the input register keeps taking items while
// a result waits, stalling only when both registers are full.
// Reset (rst, synchronous, active high): empties both registers, restores the
// gesture state and sets long_press_ms to 800 and click_gap_ms to 300.
`default_nettype none

`include "button_gesture_recognizer_top_macros.svh"

module button_gesture_recognizer_top
  import bgr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // key[1:0], pressed[2], screen_request[3], generation[35:4], now_ms[83:36], zero pad
  input  wire logic [87:0]     s_axis_tdata,
  // mode[1:0]
  input  wire logic [1:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // action_key[2:0], action_generation[34:3], zero pad
  output logic [39:0]          m_axis_tdata,
  // action[2:0]
  output logic [2:0]           m_axis_tuser,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [CfgW-1:0] cfg_data
);

  logic            in_valid;
  item_t           in_item;
  logic            out_valid;
  result_t         out_res;
  result_t         res;
  logic            adv;
  logic [CfgW-1:0] long_press_ms;
  logic [CfgW-1:0] click_gap_ms;

  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= LongPressReset;
      click_gap_ms  <= ClickGapReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgLongPress: long_press_ms <= cfg_data;
        CfgClickGap:  click_gap_ms  <= cfg_data;
        default:      long_press_ms <= long_press_ms;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.mode           <= mode_t'(s_axis_tuser);
      in_item.key            <= s_axis_tdata[1:0];
      in_item.pressed        <= s_axis_tdata[2];
      in_item.screen_request <= s_axis_tdata[3];
      in_item.generation     <= s_axis_tdata[35:4];
      in_item.now_ms         <= s_axis_tdata[83:36];
    end
  end

  bgr_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (adv),
    .item         (in_item),
    .long_press_ms(long_press_ms),
    .click_gap_ms (click_gap_ms),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res <= res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.action;
  assign m_axis_tdata  = {5'd0, out_res.action_generation, out_res.action_key};

  // checks
  `BGR_ASSERT_NEXT(a_in_loaded, s_axis_tvalid && s_axis_tready, in_valid)
  `BGR_ASSERT_NEXT(a_in_held, in_valid && !adv, in_valid && $stable(in_item))
  `BGR_ASSERT_IMP(a_act_has_key, out_valid && out_res.action != ACT_NONE,
                  out_res.action_key != NoKey)
  `BGR_ASSERT_IMP(a_off_key, out_valid && out_res.action == ACT_OFF,
                  out_res.action_key == 3'sd2)

endmodule

`default_nettype wire

FILE: tb/sv/button_gesture_recognizer_top_test.sv
`timescale 1ns / 100ps

module button_gesture_recognizer_top_test;
  import bgr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldOffCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  // key[1:0], pressed[2], screen_request[3], generation[35:4], now_ms[83:36], zero pad
  logic [87:0]   s_axis_tdata = '0;
  // mode[1:0]
  logic [1:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  // action_key[2:0], action_generation[34:3], zero pad
  logic [39:0]   m_axis_tdata;
  // action[2:0]
  logic [2:0]    m_axis_tuser;
  logic          cfg_we = 1'b0;
  logic          cfg_index = CfgLongPress;
  logic [CfgW-1:0] cfg_data = '0;

  button_gesture_recognizer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  item_t   gesture_items[$];
  result_t expected_actions[$];
  item_t   offer;
  result_t due;
  bit      sending = 1'b0;
  bit      calm = 1'b0;
  bit      hold_off_req = 1'b0;
  bit      hold_off_done = 1'b0;
  int      hold_left = 0;
  int      errors = 0;
  int      cycle_count = 0;

  // Recognizer state as the block should hold it
  logic            scr_on = 1'b1;
  logic            bar_on = 1'b0;
  logic            bar_needs_up = 1'b0;
  logic [2:0]      keys_down = '0;
  logic            run_valid = 1'b0;
  logic [1:0]      run_key = '0;
  logic            run_held = 1'b0;
  logic            long_seen = 1'b0;
  logic [1:0]      clicks = '0;
  logic [GenW-1:0] run_gen = '0;
  logic [TimeW-1:0] t_press = '0;
  logic [TimeW-1:0] t_release = '0;
  logic [TimeW-1:0] t_last = '0;
  logic [CfgW-1:0] hold_limit = LongPressReset;
  logic [CfgW-1:0] gap_limit = ClickGapReset;

  // Stimulus generator state
  logic [TimeW-1:0] clock_ms = '0;
  logic [GenW-1:0]  gen_now = '0;
  int               made = 0;

  // A span measured backwards never reaches the limit
  function automatic bit waited(logic [TimeW-1:0] now, logic [TimeW-1:0] since,
                                logic [CfgW-1:0] lim);
    return now >= since && (now - since) >= {32'd0, lim};
  endfunction

  function void drop_run();
    run_valid = 1'b0;
    run_key = '0;
    run_held = 1'b0;
    long_seen = 1'b0;
    clicks = '0;
  endfunction

  function void switch_screen(logic on, logic [TimeW-1:0] now);
    scr_on = on;
    bar_on = 1'b1;
    bar_needs_up = (keys_down != 0);
    t_last = now;
    drop_run();
  endfunction

  function void try_lift(logic [TimeW-1:0] now);
    if (bar_on && keys_down == 0 && !bar_needs_up && waited(now, t_last, gap_limit))
      bar_on = 1'b0;
  endfunction

  function automatic result_t reply(action_t a, logic signed [2:0] k, logic [GenW-1:0] g);
    result_t r;
    r.action = a;
    r.action_key = k;
    r.action_generation = g;
    return r;
  endfunction

  // One item in, one action out; updates the state above
  function automatic result_t recognize(item_t it);
    result_t    quiet;
    logic [2:0] bitm;
    logic [1:0] k;
    bit         gap_short;
    bit         goes_on;
    action_t    done;
    quiet = reply(ACT_NONE, NoKey, '0);
    case (it.mode)
      MODE_RAW: begin
        if (it.key == InvalidKey || it.now_ms < t_last) return quiet;
        try_lift(it.now_ms);
        t_last = it.now_ms;
        bitm = 3'b001 << it.key;
        if (it.pressed) begin
          if ((keys_down & bitm) != 0) return quiet;
          keys_down = keys_down | bitm;
        end else begin
          keys_down = keys_down & ~bitm;
          if (keys_down == 0) bar_needs_up = 1'b0;
        end
        if (bar_on) return quiet;
        if (!scr_on) begin
          if (!it.pressed) return quiet;
          switch_screen(1'b1, it.now_ms);
          return reply(ACT_WAKE, {1'b0, it.key}, it.generation);
        end
        if (it.pressed) begin
          gap_short = it.now_ms < t_release || (it.now_ms - t_release) < {32'd0, gap_limit};
          goes_on = run_valid && run_key == it.key && !run_held && !long_seen &&
                    run_gen == it.generation && gap_short;
          if (!goes_on) drop_run();
          run_valid = 1'b1;
          run_key = it.key;
          run_gen = it.generation;
          run_held = 1'b1;
          t_press = it.now_ms;
          return quiet;
        end
        if (!run_valid || run_key != it.key || !run_held || run_gen != it.generation)
          return quiet;
        run_held = 1'b0;
        t_release = it.now_ms;
        if (long_seen) begin
          drop_run();
          return quiet;
        end
        if (waited(it.now_ms, t_press, hold_limit)) begin
          drop_run();
          return reply(ACT_LONG, {1'b0, it.key}, run_gen);
        end
        if (clicks < TripleCount) clicks = clicks + 2'd1;
        if (it.key == TripleKey && clicks == TripleCount) begin
          switch_screen(1'b0, it.now_ms);
          return reply(ACT_OFF, {1'b0, it.key}, run_gen);
        end
        return quiet;
      end
      MODE_TICK: begin
        try_lift(it.now_ms);
        if (bar_on || !scr_on || !run_valid) return quiet;
        if (run_gen != it.generation) begin
          drop_run();
          return quiet;
        end
        if (run_held && !long_seen && waited(it.now_ms, t_press, hold_limit)) begin
          long_seen = 1'b1;
          clicks = '0;
          return reply(ACT_LONG, {1'b0, run_key}, run_gen);
        end
        // gap over: report the run, plain none when it held no click or double
        if (!run_held && waited(it.now_ms, t_release, gap_limit)) begin
          k = run_key;
          done = (clicks == 2'd1) ? ACT_CLICK : (clicks == 2'd2) ? ACT_DOUBLE : ACT_NONE;
          drop_run();
          return reply(done, {1'b0, k}, run_gen);
        end
        return quiet;
      end
      MODE_SCREEN: begin
        switch_screen(it.screen_request, it.now_ms);
        return quiet;
      end
      default: begin
        bar_on = 1'b1;
        bar_needs_up = 1'b1;
        t_last = it.now_ms;
        keys_down = '0;
        drop_run();
        return quiet;
      end
    endcase
  endfunction

  function automatic logic [TimeW-1:0] below(logic [CfgW-1:0] lim);
    return (lim <= 16'd1) ? '0 : TimeW'($urandom_range(32'(lim) - 1));
  endfunction

  function automatic logic [TimeW-1:0] beyond(logic [CfgW-1:0] lim);
    return {32'd0, lim} + TimeW'($urandom_range(32'(lim)));
  endfunction

  task automatic post(mode_t m, logic [1:0] k, logic p, logic s, logic [GenW-1:0] g,
                      logic [TimeW-1:0] t);
    item_t it;
    it.mode = m;
    it.key = k;
    it.pressed = p;
    it.screen_request = s;
    it.generation = g;
    it.now_ms = t;
    gesture_items.push_back(it);
    made++;
  endtask

  task automatic key_event(logic [1:0] k, logic p);
    post(MODE_RAW, k, p, 1'($urandom_range(1)), gen_now, clock_ms);
  endtask

  task automatic tick_event();
    post(MODE_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
         gen_now, clock_ms);
  endtask

  // One well-formed gesture with random timing, or a noise item
  task automatic add_gesture();
    int          kind;
    int          n;
    logic [1:0]  k;
    logic [1:0]  k2;
    logic [63:0] wide;
    logic [TimeW-1:0] t;
    kind = $urandom_range(99);
    k = 2'($urandom_range(2));
    k2 = 2'((int'(k) + $urandom_range(2, 1)) % 3);
    clock_ms += ($urandom_range(3) == 0) ? below(gap_limit) : beyond(gap_limit);
    if (kind < 45) begin
      // click runs; some are triples on the screen-off key, then a wake
      if (kind >= 30) begin
        k = TripleKey;
        n = 3;
      end else begin
        n = $urandom_range(4, 1);
      end
      repeat (n) begin
        key_event(k, 1'b1);
        clock_ms += below(hold_limit / 2);
        if ($urandom_range(2) == 0) tick_event();
        clock_ms += below(hold_limit / 2);
        key_event(k, 1'b0);
        clock_ms += below(gap_limit);
        if ($urandom_range(2) == 0) tick_event();
      end
      clock_ms += beyond(gap_limit);
      tick_event();
      if (kind >= 30) begin
        key_event(k2, 1'b1);
        clock_ms += below(hold_limit);
        key_event(k2, 1'b0);
      end
    end else if (kind < 62) begin
      // long press, seen by a tick or by the release
      key_event(k, 1'b1);
      clock_ms += beyond(hold_limit);
      if ($urandom_range(1)) begin
        tick_event();
        if ($urandom_range(1)) begin
          clock_ms += below(gap_limit);
          tick_event();
        end
      end
      clock_ms += below(gap_limit);
      key_event(k, 1'b0);
    end else if (kind < 72) begin
      // overlapping keys
      key_event(k, 1'b1);
      clock_ms += below(hold_limit);
      key_event(k2, 1'b1);
      clock_ms += below(hold_limit);
      key_event(k, 1'b0);
      tick_event();
      clock_ms += below(hold_limit);
      key_event(k2, 1'b0);
      clock_ms += beyond(gap_limit);
      tick_event();
    end else if (kind < 82) begin
      // screen change or cancel, maybe with a key down
      if ($urandom_range(1)) key_event(k, 1'b1);
      clock_ms += below(hold_limit);
      if ($urandom_range(2) == 0)
        post(MODE_CANCEL, 2'($urandom_range(3)), 1'($urandom_range(1)),
             1'($urandom_range(1)), $urandom, clock_ms);
      else
        post(MODE_SCREEN, 2'($urandom_range(3)), 1'($urandom_range(1)),
             1'($urandom_range(1)), $urandom, clock_ms);
      clock_ms += below(gap_limit);
      key_event(k, 1'b0);
      clock_ms += beyond(gap_limit);
      tick_event();
    end else if (kind < 90) begin
      // context changes in the middle of a press
      key_event(k, 1'b1);
      clock_ms += below(hold_limit);
      gen_now = $urandom;
      if ($urandom_range(1)) tick_event();
      key_event(k, 1'b0);
      clock_ms += beyond(gap_limit);
      tick_event();
    end else begin
      // noise: any mode, any key, time slightly off or anywhere for ticks
      wide = {$urandom, $urandom};
      case ($urandom_range(2))
        0: t = clock_ms + TimeW'($urandom_range(20));
        1: t = clock_ms - TimeW'($urandom_range(20));
        default: t = wide[TimeW-1:0];
      endcase
      n = $urandom_range(3);
      if (n != MODE_TICK && t > clock_ms + 48'd20) t = clock_ms;
      post(mode_t'(n), 2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
           ($urandom_range(3) == 0) ? $urandom : gen_now, t);
    end
  endtask

  task automatic settle();
    while (gesture_items.size() != 0 || sending || expected_actions.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int n);
    made = 0;
    while (made < n) add_gesture();
    settle();
  endtask

  task automatic set_timing(logic [CfgW-1:0] hold, logic [CfgW-1:0] gap);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgLongPress;
    cfg_data <= hold;
    hold_limit = hold;
    @(posedge clk);
    cfg_index <= CfgClickGap;
    cfg_data <= gap;
    gap_limit = gap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: predict on accept, then hold, idle or offer the next item
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_actions.push_back(recognize(offer));
        sending = 1'b0;
      end
      if (!sending) begin
        if (gesture_items.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
          offer = gesture_items.pop_front();
          sending = 1'b1;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'd0, offer.now_ms, offer.generation, offer.screen_request,
                           offer.pressed, offer.key};
          s_axis_tuser <= offer.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each action, stall at random or for one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_actions.size() == 0) begin
          errors++;
          $display("%0t: unexpected item: action %0d key %0d gen %h", $time, m_axis_tuser,
                   $signed(m_axis_tdata[2:0]), m_axis_tdata[34:3]);
        end else begin
          due = expected_actions.pop_front();
          if (m_axis_tuser !== due.action) begin
            errors++;
            $display("%0t: action expected %0d got %0d", $time, due.action, m_axis_tuser);
          end
          if (m_axis_tdata[2:0] !== due.action_key) begin
            errors++;
            $display("%0t: action_key expected %0d got %0d", $time, due.action_key,
                     $signed(m_axis_tdata[2:0]));
          end
          if (m_axis_tdata[34:3] !== due.action_generation) begin
            errors++;
            $display("%0t: action_generation expected %h got %h", $time,
                     due.action_generation, m_axis_tdata[34:3]);
          end
        end
      end
      if (hold_off_req && !hold_off_done) begin
        hold_left = HoldOffCycles;
        hold_off_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("button_gesture_recognizer_top: mismatch");
      $finish;
    end
  end

  initial begin
    logic [GenW-1:0] ga;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    gen_now = $urandom;
    ga = gen_now;

    // Directed: field extremes, each mode and the corner cases, reset timing
    post(MODE_TICK, InvalidKey, 1'b1, 1'b1, '1, '1);
    post(MODE_RAW, InvalidKey, 1'b1, 1'b0, ga, 48'd10);       // invalid key
    post(MODE_RAW, 2'd0, 1'b1, 1'b0, ga, 48'd100);
    post(MODE_RAW, 2'd0, 1'b1, 1'b1, ga, 48'd110);            // key already down
    post(MODE_RAW, 2'd1, 1'b0, 1'b0, ga, 48'd120);            // release of another key
    post(MODE_RAW, 2'd0, 1'b0, 1'b0, ga, 48'd200);
    post(MODE_TICK, 2'd0, 1'b0, 1'b0, ga, 48'd150);           // tick before release stamp
    post(MODE_TICK, 2'd0, 1'b0, 1'b0, ga, 48'd600);           // click
    post(MODE_RAW, 2'd1, 1'b1, 1'b0, ga, 48'd150);            // time goes back
    post(MODE_RAW, 2'd1, 1'b1, 1'b0, ga, 48'd700);
    post(MODE_TICK, 2'd1, 1'b0, 1'b0, ga, 48'd1600);          // long by tick
    post(MODE_RAW, 2'd1, 1'b0, 1'b0, ga, 48'd1700);
    post(MODE_RAW, TripleKey, 1'b1, 1'b0, ga, 48'd2000);      // triple: screen off
    post(MODE_RAW, TripleKey, 1'b0, 1'b0, ga, 48'd2010);
    post(MODE_RAW, TripleKey, 1'b1, 1'b0, ga, 48'd2020);
    post(MODE_RAW, TripleKey, 1'b0, 1'b0, ga, 48'd2030);
    post(MODE_RAW, TripleKey, 1'b1, 1'b0, ga, 48'd2040);
    post(MODE_RAW, TripleKey, 1'b0, 1'b0, ga, 48'd2050);
    post(MODE_RAW, 2'd0, 1'b1, 1'b0, ga, 48'd2060);           // blocked by barrier
    post(MODE_RAW, 2'd0, 1'b0, 1'b0, ga, 48'd2070);
    post(MODE_RAW, 2'd1, 1'b1, 1'b0, ga, 48'd2500);           // wake
    post(MODE_RAW, 2'd1, 1'b0, 1'b0, ga, 48'd2510);
    post(MODE_SCREEN, 2'd0, 1'b0, 1'b0, ~ga, 48'd2600);
    post(MODE_CANCEL, InvalidKey, 1'b1, 1'b1, '0, 48'd2700);
    settle();

    clock_ms = 48'd3000;
    run_phase(150);

    // no idling on either side
    set_timing(16'd40, 16'd15);
    calm = 1'b1;
    run_phase(500);
    calm = 1'b0;

    set_timing(16'd1, 16'd1);
    run_phase(200);

    set_timing(16'd0, 16'd0);
    run_phase(100);

    set_timing(16'hFFFF, 16'hFFFF);
    run_phase(150);

    // receiver holds off while the sender keeps offering
    set_timing(16'd25, 16'd60);
    clock_ms = {16'h0000, 2'b01, 30'($urandom)};
    hold_off_req = 1'b1;
    run_phase(300);

    set_timing(16'd200, 16'd30);
    clock_ms = {16'hFFFF, 2'b10, 30'($urandom)};
    run_phase(350);

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("button_gesture_recognizer_top: match");
    end else begin
      $display("button_gesture_recognizer_top: mismatch");
    end
    $finish;
  end

endmodule
